// ===== rtl/bma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_pkg
// Shared constants, types and helper functions of the buddy allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

	localparam int MEM_UNITS   = 1024;
	localparam int OWNER_COUNT = 256;
	localparam int LOG_UNITS   = $clog2(MEM_UNITS);
	localparam int NODE_COUNT  = 2 * MEM_UNITS - 1;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int LVL_W       = $clog2(LOG_UNITS + 1);
	localparam int SIZE_W      = LOG_UNITS + 1;
	localparam int ADDR_W      = LOG_UNITS;
	localparam int OWNER_W     = 8;
	localparam int OWNER_AW    = $clog2(OWNER_COUNT);
	localparam int REQ_W       = 11;

	typedef enum logic [1:0] {
		NS_ABSENT = 2'd0,
		NS_FREE   = 2'd1,
		NS_SPLIT  = 2'd2,
		NS_ALLOC  = 2'd3
	} node_st_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SPLIT,
		ST_ALLOC,
		ST_REL,
		ST_MERGE_RD,
		ST_MERGE_CHK,
		ST_MERGE_WR,
		ST_RESP
	} fsm_t;

	// smallest c with 2**c >= v, for 1 <= v <= MEM_UNITS
	function automatic logic [LVL_W-1:0] ceil_log2(input logic [REQ_W-1:0] v);
		logic [LVL_W-1:0] c;
		c = '0;
		for (int i = LOG_UNITS; i >= 0; i--) begin
			if ((REQ_W'(1) << i) >= v)
				c = LVL_W'(i);
		end
		return c;
	endfunction

	// tree level of a node index: position of the top bit of n + 1
	function automatic logic [LVL_W-1:0] node_level(input logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] m;
		logic [LVL_W-1:0]  d;
		m = n + NODE_W'(1);
		d = '0;
		for (int i = 0; i < NODE_W; i++) begin
			if (m[i])
				d = LVL_W'(i);
		end
		return d;
	endfunction

endpackage

// ===== rtl/bma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bma_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/buddy_memory_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_memory_allocator
// Binary buddy allocator; node states live in a RAM walked by a sequencer.
// ----------------------------------------------------------------------------
// Sequence: an allocate scans its target level, then each level above, for a
//   free node, splits down to the target and marks it; a release frees the
//   owner's node and merges free buddies upward; rejects go to the result.
// Throughput: one item at a time, the next taken right after the result is
//   registered; a scan may cover all 2047 nodes. Output stalls hold the sequencer.
// Reset: a clearing pass rewrites the tree; owner valid bits clear.
module buddy_memory_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // owner[7:0], req_size[18:8], zero fill
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // ok[0], block_start[10:1], block_end[20:11], zero fill
);
	import bma_pkg::*;

	fsm_t state_q, state_d;

	logic [OWNER_W-1:0] owner_q, owner_d;
	logic [LVL_W-1:0]   tgt_q, tgt_d;
	logic [LVL_W-1:0]   lvl_q, lvl_d;
	logic [ADDR_W-1:0]  k_q, k_d;
	logic [NODE_W-1:0]  n_q, n_d;
	logic [1:0]         wstep_q, wstep_d;
	logic [NODE_W-1:0]  clr_q, clr_d;
	logic [SIZE_W-1:0]  free_q, free_d;
	logic               pok_q, pok_d;
	logic [ADDR_W-1:0]  pstart_q, pstart_d;
	logic [ADDR_W-1:0]  pend_q, pend_d;
	logic               own_valid_q [OWNER_COUNT];
	logic               vset, vclr;

	logic               res_valid_q;
	logic [20:0]        res_q;

	// node status RAM
	logic               ns_we;
	logic [NODE_W-1:0]  ns_waddr, ns_raddr;
	logic [1:0]         ns_wdata, ns_rdata;
	// owner to node RAM
	logic               on_we;
	logic [NODE_W-1:0]  on_rdata;

	logic [OWNER_W-1:0] in_owner;
	logic [REQ_W-1:0]   in_req;
	logic [LVL_W-1:0]   in_clog;
	logic [SIZE_W-1:0]  in_round;
	logic [NODE_W-1:0]  lvl_first, scan_node, left_child, sibling, parent;
	logic [ADDR_W-1:0]  k_last;
	logic [SIZE_W-1:0]  r_size;

	assign in_owner = s_tdata[7:0];
	assign in_req   = s_tdata[18:8];
	assign in_clog  = ceil_log2(in_req);
	assign in_round = SIZE_W'(1) << in_clog;

	assign lvl_first  = (NODE_W'(1) << lvl_q) - NODE_W'(1);
	assign scan_node  = lvl_first + NODE_W'(k_q);
	assign k_last     = ADDR_W'(lvl_first);
	assign left_child = {n_q[NODE_W-2:0], 1'b1};
	assign sibling    = n_q[0] ? n_q + NODE_W'(1) : n_q - NODE_W'(1);
	assign parent     = (n_q - NODE_W'(1)) >> 1;
	assign r_size     = SIZE_W'(MEM_UNITS) >> tgt_q;

	bma_ram #(.WIDTH(2), .DEPTH(NODE_COUNT), .AW(NODE_W)) u_status (
		.clk   (clk),
		.we    (ns_we),
		.waddr (ns_waddr),
		.wdata (ns_wdata),
		.raddr (ns_raddr),
		.rdata (ns_rdata)
	);

	bma_ram #(.WIDTH(NODE_W), .DEPTH(OWNER_COUNT), .AW(OWNER_AW)) u_owner (
		.clk   (clk),
		.we    (on_we),
		.waddr (OWNER_AW'(owner_q)),
		.wdata (n_q),
		.raddr (OWNER_AW'(in_owner)),
		.rdata (on_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = res_valid_q;
	assign m_tdata  = {3'b000, res_q};

	always_comb begin
		state_d  = state_q;
		owner_d  = owner_q;
		tgt_d    = tgt_q;
		lvl_d    = lvl_q;
		k_d      = k_q;
		n_d      = n_q;
		wstep_d  = wstep_q;
		clr_d    = clr_q;
		free_d   = free_q;
		pok_d    = pok_q;
		pstart_d = pstart_q;
		pend_d   = pend_q;
		ns_we    = 1'b0;
		ns_waddr = n_q;
		ns_wdata = NS_ABSENT;
		ns_raddr = scan_node;
		on_we    = 1'b0;
		vset     = 1'b0;
		vclr     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ns_we    = 1'b1;
				ns_waddr = clr_q;
				ns_wdata = (clr_q == '0) ? NS_FREE : NS_ABSENT;
				clr_d    = clr_q + NODE_W'(1);
				if (clr_q == NODE_W'(NODE_COUNT - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				pok_d    = 1'b0;
				pstart_d = '0;
				pend_d   = '0;
				owner_d  = in_owner;
				if (s_tvalid) begin
					if (!s_tuser) begin
						tgt_d = LVL_W'(LOG_UNITS) - in_clog;
						lvl_d = LVL_W'(LOG_UNITS) - in_clog;
						k_d   = '0;
						if (in_req == '0 || in_req > REQ_W'(MEM_UNITS)
								|| own_valid_q[OWNER_AW'(in_owner)]
								|| in_round > free_q)
							state_d = ST_RESP;
						else
							state_d = ST_SCAN_RD;
					end else begin
						if (own_valid_q[OWNER_AW'(in_owner)])
							state_d = ST_REL;
						else
							state_d = ST_RESP;
					end
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (ns_rdata == NS_FREE) begin
					n_d      = scan_node;
					pstart_d = ADDR_W'(k_q << (LVL_W'(LOG_UNITS) - lvl_q));
					wstep_d  = '0;
					state_d  = (lvl_q == tgt_q) ? ST_ALLOC : ST_SPLIT;
				end else if (k_q == k_last) begin
					if (lvl_q == '0)
						state_d = ST_RESP;
					else begin
						lvl_d   = lvl_q - LVL_W'(1);
						k_d     = '0;
						state_d = ST_SCAN_RD;
					end
				end else begin
					k_d     = k_q + ADDR_W'(1);
					state_d = ST_SCAN_RD;
				end
			end
			ST_SPLIT: begin
				ns_we   = 1'b1;
				wstep_d = wstep_q + 2'd1;
				case (wstep_q)
					2'd0: begin
						ns_waddr = left_child;
						ns_wdata = NS_FREE;
					end
					2'd1: begin
						ns_waddr = left_child + NODE_W'(1);
						ns_wdata = NS_FREE;
					end
					default: begin
						ns_wdata = NS_SPLIT;
						n_d      = left_child;
						lvl_d    = lvl_q + LVL_W'(1);
						wstep_d  = '0;
						if (lvl_q + LVL_W'(1) == tgt_q)
							state_d = ST_ALLOC;
					end
				endcase
			end
			ST_ALLOC: begin
				ns_we    = 1'b1;
				ns_wdata = NS_ALLOC;
				on_we    = 1'b1;
				vset     = 1'b1;
				free_d   = free_q - r_size;
				pok_d    = 1'b1;
				pend_d   = pstart_q + ADDR_W'(r_size - SIZE_W'(1));
				state_d  = ST_RESP;
			end
			ST_REL: begin
				// owner RAM data is valid here
				n_d      = on_rdata;
				ns_we    = 1'b1;
				ns_waddr = on_rdata;
				ns_wdata = NS_FREE;
				vclr     = 1'b1;
				free_d   = free_q + (SIZE_W'(MEM_UNITS) >> node_level(on_rdata));
				pok_d    = 1'b1;
				state_d  = (on_rdata == '0) ? ST_RESP : ST_MERGE_RD;
			end
			ST_MERGE_RD: begin
				ns_raddr = sibling;
				state_d  = ST_MERGE_CHK;
			end
			ST_MERGE_CHK: begin
				wstep_d = '0;
				state_d = (ns_rdata == NS_FREE) ? ST_MERGE_WR : ST_RESP;
			end
			ST_MERGE_WR: begin
				ns_we   = 1'b1;
				wstep_d = wstep_q + 2'd1;
				case (wstep_q)
					2'd0: begin
						ns_waddr = sibling;
						ns_wdata = NS_ABSENT;
					end
					2'd1: begin
						ns_wdata = NS_ABSENT;
					end
					default: begin
						ns_waddr = parent;
						ns_wdata = NS_FREE;
						n_d      = parent;
						state_d  = (parent == '0) ? ST_RESP : ST_MERGE_RD;
					end
				endcase
			end
			ST_RESP: begin
				// hold until the output register is free
				if (!res_valid_q || m_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			free_q      <= SIZE_W'(MEM_UNITS);
			res_valid_q <= 1'b0;
			wstep_q     <= '0;
			for (int i = 0; i < OWNER_COUNT; i++)
				own_valid_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			free_q  <= free_d;
			wstep_q <= wstep_d;
			if (vset)
				own_valid_q[OWNER_AW'(owner_q)] <= 1'b1;
			if (vclr)
				own_valid_q[OWNER_AW'(owner_q)] <= 1'b0;
			if (state_q == ST_RESP && (!res_valid_q || m_tready))
				res_valid_q <= 1'b1;
			else if (m_tready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		owner_q  <= owner_d;
		tgt_q    <= tgt_d;
		lvl_q    <= lvl_d;
		k_q      <= k_d;
		n_q      <= n_d;
		pok_q    <= pok_d;
		pstart_q <= pstart_d;
		pend_q   <= pend_d;
		if (state_q == ST_RESP && (!res_valid_q || m_tready))
			res_q <= {pend_q, pok_q ? pstart_q : ADDR_W'(0), pok_q};
	end

endmodule
